>>> hdl/tdc_pkg.sv
package tdc_pkg;

  localparam int CMD_W  = 4;
  localparam int SETV_W = 7;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int SEL_W  = 2;
  localparam int TPS_W  = 16;

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd900;
  localparam logic [SEC_W-1:0] SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0] MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 4'd0,
    CMD_EDIT    = 4'd1,
    CMD_SAVE    = 4'd2,
    CMD_DISCARD = 4'd3,
    CMD_RIGHT   = 4'd4,
    CMD_LEFT    = 4'd5,
    CMD_UP      = 4'd6,
    CMD_DOWN    = 4'd7,
    CMD_SET     = 4'd8
  } cmd_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_SEC  = 2'd0,
    SEL_MIN  = 2'd1,
    SEL_HOUR = 2'd2
  } sel_t;

endpackage

>>> hdl/tdc_if.sv
interface tdc_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdc_pkg::CMD_W-1:0]  cmd;
  logic [tdc_pkg::SETV_W-1:0] set_hours;
  logic [tdc_pkg::SETV_W-1:0] set_minutes;
  logic [tdc_pkg::SETV_W-1:0] set_seconds;

  modport source (output valid, cmd, set_hours, set_minutes, set_seconds, input ready);
  modport sink (input valid, cmd, set_hours, set_minutes, set_seconds, output ready);
endinterface

interface tdc_out_if;
  logic                       valid;
  logic                       ready;
  logic [tdc_pkg::HOUR_W-1:0] hours;
  logic [tdc_pkg::MIN_W-1:0]  minutes;
  logic [tdc_pkg::SEC_W-1:0]  seconds;
  logic                       editing;
  logic [tdc_pkg::SEL_W-1:0]  field_selected;
  logic                       set_rejected;

  modport source (output valid, hours, minutes, seconds, editing, field_selected,
                  set_rejected, input ready);
  modport sink (input valid, hours, minutes, seconds, editing, field_selected,
                set_rejected, output ready);
endinterface

>>> hdl/time_of_day_clock_with_edit.sv
// An accepted item enters the input register, then the time registers, which drive
// the result. One item per cycle when not stalled; the two form a two-stage pipeline,
// and ready stalls only when both stages hold an item and out_chan.ready is low.
// Reset (rst_n low, synchronous) clears the time, the saved copy, the prescaler,
// edit mode and the selection, empties both stages and sets ticks_per_second to 900.
module time_of_day_clock_with_edit (
  input  logic                        clk,
  input  logic                        rst_n,
  tdc_in_if.sink                      in_chan,
  tdc_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [tdc_pkg::TPS_W-1:0]   cfg_data
);
  import tdc_pkg::*;

  logic [TPS_W-1:0]  tps_r;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [SETV_W-1:0] s1_sh_r, s1_sm_r, s1_ss_r;

  logic              out_valid_r;
  logic [TPS_W-1:0]  pre_r, pre_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt, sav_h_r, sav_h_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt, sav_m_r, sav_m_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt, sav_s_r, sav_s_nxt;
  logic              edit_r, edit_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic              rej_r, rej_nxt;

  logic              adv;
  logic [TPS_W-1:0]  limit, pre_inc;

  assign adv           = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r <= in_chan.cmd;
      s1_sh_r  <= in_chan.set_hours;
      s1_sm_r  <= in_chan.set_minutes;
      s1_ss_r  <= in_chan.set_seconds;
    end
  end

  assign limit   = (tps_r == '0) ? TPS_W'(1) : tps_r;
  assign pre_inc = pre_r + TPS_W'(1);

  always_comb begin
    pre_nxt   = pre_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    sav_h_nxt = sav_h_r;
    sav_m_nxt = sav_m_r;
    sav_s_nxt = sav_s_r;
    edit_nxt  = edit_r;
    sel_nxt   = sel_r;
    rej_nxt   = 1'b0;

    unique case (cmd_t'(s1_cmd_r))
      CMD_TICK: begin
        if (!edit_r) begin
          if (pre_inc >= limit) begin
            pre_nxt = pre_inc - limit;
            if (sec_r >= SEC_MAX) begin
              sec_nxt = '0;
              if (min_r >= MIN_MAX) begin
                min_nxt = '0;
                hour_nxt = (hour_r >= HOUR_MAX) ? '0 : hour_r + HOUR_W'(1);
              end else begin
                min_nxt = min_r + MIN_W'(1);
              end
            end else begin
              sec_nxt = sec_r + SEC_W'(1);
            end
          end else begin
            pre_nxt = pre_inc;
          end
        end
      end
      CMD_EDIT, CMD_RIGHT, CMD_LEFT: begin
        if (!edit_r) begin
          pre_nxt   = '0;
          edit_nxt  = 1'b1;
          sav_h_nxt = hour_r;
          sav_m_nxt = min_r;
          sav_s_nxt = sec_r;
        end
        if (cmd_t'(s1_cmd_r) == CMD_RIGHT) begin
          unique case (sel_r)
            SEL_MIN:  sel_nxt = SEL_SEC;
            SEL_HOUR: sel_nxt = SEL_MIN;
            default:  sel_nxt = SEL_HOUR;
          endcase
        end else if (cmd_t'(s1_cmd_r) == CMD_LEFT) begin
          unique case (sel_r)
            SEL_SEC: sel_nxt = SEL_MIN;
            SEL_MIN: sel_nxt = SEL_HOUR;
            default: sel_nxt = SEL_SEC;
          endcase
        end
      end
      CMD_SAVE: begin
        edit_nxt = 1'b0;
      end
      CMD_DISCARD: begin
        if (edit_r) begin
          hour_nxt = sav_h_r;
          min_nxt  = sav_m_r;
          sec_nxt  = sav_s_r;
          edit_nxt = 1'b0;
        end
      end
      CMD_UP: begin
        if (edit_r) begin
          unique case (sel_r)
            SEL_SEC:  sec_nxt  = (sec_r >= SEC_MAX) ? '0 : sec_r + SEC_W'(1);
            SEL_MIN:  min_nxt  = (min_r >= MIN_MAX) ? '0 : min_r + MIN_W'(1);
            SEL_HOUR: hour_nxt = (hour_r >= HOUR_MAX) ? '0 : hour_r + HOUR_W'(1);
            default: ;
          endcase
        end
      end
      CMD_DOWN: begin
        if (edit_r) begin
          unique case (sel_r)
            SEL_SEC:  sec_nxt  = (sec_r == '0 || sec_r > SEC_MAX) ? SEC_MAX
                                                                  : sec_r - SEC_W'(1);
            SEL_MIN:  min_nxt  = (min_r == '0 || min_r > MIN_MAX) ? MIN_MAX
                                                                  : min_r - MIN_W'(1);
            SEL_HOUR: hour_nxt = (hour_r == '0 || hour_r > HOUR_MAX) ? HOUR_MAX
                                                                     : hour_r - HOUR_W'(1);
            default: ;
          endcase
        end
      end
      CMD_SET: begin
        pre_nxt   = '0;
        sav_h_nxt = hour_r;
        sav_m_nxt = min_r;
        sav_s_nxt = sec_r;
        if (s1_sh_r > SETV_W'(HOUR_MAX) || s1_sm_r > SETV_W'(MIN_MAX) ||
            s1_ss_r > SETV_W'(SEC_MAX)) begin
          rej_nxt = 1'b1;
        end else begin
          hour_nxt = s1_sh_r[HOUR_W-1:0];
          min_nxt  = s1_sm_r[MIN_W-1:0];
          sec_nxt  = s1_ss_r[SEC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pre_r       <= '0;
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      sav_h_r     <= '0;
      sav_m_r     <= '0;
      sav_s_r     <= '0;
      edit_r      <= 1'b0;
      sel_r       <= SEL_SEC;
      rej_r       <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      pre_r       <= pre_nxt;
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      sav_h_r     <= sav_h_nxt;
      sav_m_r     <= sav_m_nxt;
      sav_s_r     <= sav_s_nxt;
      edit_r      <= edit_nxt;
      sel_r       <= sel_nxt;
      rej_r       <= rej_nxt;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.hours          = hour_r;
  assign out_chan.minutes        = min_r;
  assign out_chan.seconds        = sec_r;
  assign out_chan.editing        = edit_r;
  assign out_chan.field_selected = sel_r;
  assign out_chan.set_rejected   = rej_r;

`ifndef NO_ASSERTIONS
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r <= HOUR_MAX && min_r <= MIN_MAX && sec_r <= SEC_MAX)
    else $error("Time registers hold an out-of-range value.");

  a_edit_prescaler: assert property (@(posedge clk) disable iff (!rst_n)
    edit_r |-> pre_r == '0)
    else $error("Prescaler is not clear while editing.");

  a_frozen_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_cmd_r == CMD_TICK && edit_r) |=>
      ($stable(hour_r) && $stable(min_r) && $stable(sec_r)))
    else $error("A tick changed the time during edit mode.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("Input stalled while the result register is empty.");
`endif

endmodule
